// ----- hw/rtl/swrr_pkg.sv -----
package swrr_pkg;

    localparam logic [2:0] KIND_SET     = 3'd0;
    localparam logic [2:0] KIND_RECALC  = 3'd1;
    localparam logic [2:0] KIND_SELECT  = 3'd2;
    localparam logic [2:0] KIND_REFUND  = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;

    localparam logic [31:0] FULL_SHARE = 32'd65536;

    localparam int SPEC_W   = 16;
    localparam int NORM_W   = 17;
    localparam int CREDIT_W = 32;

    // per-channel table entry: spec weight, active, available, normalized weight
    typedef struct packed {
        logic [SPEC_W-1:0] spec;
        logic              act;
        logic              avl;
        logic [NORM_W-1:0] norm;
    } t_chan;

    localparam int CHAN_W = $bits(t_chan);

endpackage

// ----- hw/rtl/swrr_ram.sv -----
module swrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hw/rtl/smooth_weighted_round_robin_unit.sv -----
// Smooth weighted round robin arbiter. Raise i_start while o_busy is low to
// issue one transaction; exactly one result follows on o_done, held for one
// cycle, and the receiver cannot stall it. Channel and credit tables live in
// two RAMs with one registered read port each; recompute and select walk the
// N channels in use (N up to MAX_CHANNELS), the sum and update walks reading
// one channel per cycle, and clear zeroes those channels' credits. Set and
// refund write one entry of a valid channel; an unknown kind writes nothing.
// Recompute sums eligible weights, then runs a 32-step shift-subtract divider
// once per eligible channel (not when none is eligible). Select does a credit
// update and compare walk, a 32-step remainder of the random word by the tie
// count, then a tie scan (neither when nothing is selectable). o_done rises
// in the first cycle with o_busy low. After reset a clearing pass wipes all
// MAX_CHANNELS entries of both tables while o_busy is high.
module smooth_weighted_round_robin_unit #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_kind,
    input  logic [2:0]  i_channel,
    input  logic [15:0] i_spec_weight,
    input  logic        i_active,
    input  logic        i_available,
    input  logic [31:0] i_tie_random,
    output logic        o_done,
    output logic        o_chosen_valid,
    output logic [2:0]  o_chosen_channel,
    output logic signed [31:0] o_chosen_credit
);

    localparam int AW = $clog2(MAX_CHANNELS);
    localparam int CW = $clog2(MAX_CHANNELS + 1);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WB     = 4'd2;
    localparam logic [3:0] S_CLRC   = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_NRD    = 4'd5;
    localparam logic [3:0] S_NLD    = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_NWB    = 4'd8;
    localparam logic [3:0] S_UPD    = 4'd9;
    localparam logic [3:0] S_SCAN   = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    logic [3:0]        r_state, n_state;
    logic [3:0]        r_cfg;
    logic [2:0]        r_kind;
    logic [2:0]        r_ch;
    logic [15:0]       r_spec;
    logic              r_act, r_avl;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_used;
    logic              r_rv;
    logic [AW-1:0]     r_pa;
    logic [31:0]       r_total;
    logic [CW-1:0]     r_elig;
    logic [31:0]       r_div;
    logic              r_eq;
    swrr_pkg::t_chan   r_ent;
    logic [31:0]       r_dvd;
    logic [31:0]       r_rem;
    logic [swrr_pkg::NORM_W-1:0] r_quo;
    logic [4:0]        r_step;
    logic [31:0]       r_best;
    logic [CW-1:0]     r_cnt;
    logic              r_any;
    logic [MAX_CHANNELS-1:0] r_tie;
    logic [CW-1:0]     r_seen;
    logic [AW-1:0]     r_win;
    logic              r_done, r_val;
    logic [2:0]        r_och;
    logic [31:0]       r_ocr;

    logic              t_we, c_we;
    logic [AW-1:0]     t_wa, t_ra, c_wa, c_ra;
    swrr_pkg::t_chan   t_wd, t_rd;
    logic [31:0]       c_wd, c_rd;

    swrr_ram #(.WIDTH(swrr_pkg::CHAN_W), .DEPTH(MAX_CHANNELS)) u_chan (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd)
    );
    swrr_ram #(.WIDTH(swrr_pkg::CREDIT_W), .DEPTH(MAX_CHANNELS)) u_cred (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_raddr(c_ra), .o_rdata(c_rd)
    );

    logic [CW-1:0] used_c;
    always_comb begin
        if (32'(r_cfg) > 32'(MAX_CHANNELS)) begin
            used_c = CW'(MAX_CHANNELS);
        end else begin
            used_c = CW'(r_cfg);
        end
    end

    // read data in a walk belongs to r_pa, the address issued in the previous cycle
    logic          sel_ok, elig_ok, walk_end;
    logic [31:0]   cred_add;
    logic [31:0]   key_add, key_best;
    logic [31:0]   div_den;
    logic [32:0]   rem_sh, rem_sub;
    logic          take;
    assign sel_ok   = t_rd.act && (t_rd.norm != '0);
    assign elig_ok  = t_rd.act && t_rd.avl;
    assign walk_end = (r_idx >= r_used) && !r_rv;
    assign cred_add = c_rd + 32'(t_rd.norm);
    assign key_add  = cred_add ^ 32'h8000_0000;
    assign key_best = r_best ^ 32'h8000_0000;
    assign div_den  = (r_kind == swrr_pkg::KIND_SELECT) ? 32'(r_cnt) : r_div;
    assign rem_sh   = {r_rem, r_dvd[31]};
    assign rem_sub  = rem_sh - {1'b0, div_den};
    assign take     = !rem_sub[32];

    always_comb begin
        n_state = r_state;
        t_we = 1'b0; t_wa = AW'(r_idx); t_wd = t_rd;     t_ra = AW'(r_idx);
        c_we = 1'b0; c_wa = r_pa;       c_wd = cred_add; c_ra = AW'(r_idx);
        unique case (r_state)
            S_CLR: begin
                t_we = 1'b1; t_wd = '0;
                c_we = 1'b1; c_wa = AW'(r_idx); c_wd = '0;
                if (r_idx == CW'(MAX_CHANNELS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                t_ra = AW'(i_channel);
                c_ra = AW'(i_channel);
                if (i_start) begin
                    unique case (i_kind)
                        swrr_pkg::KIND_SET:
                            n_state = (32'(i_channel) < 32'(MAX_CHANNELS)) ? S_WB : S_FIN;
                        swrr_pkg::KIND_REFUND:
                            n_state = (32'(i_channel) < 32'(used_c)) ? S_WB : S_FIN;
                        swrr_pkg::KIND_CLEAR:
                            n_state = (used_c == '0) ? S_FIN : S_CLRC;
                        swrr_pkg::KIND_RECALC: n_state = S_SUM;
                        swrr_pkg::KIND_SELECT: n_state = S_UPD;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_WB: begin
                t_wa = AW'(r_ch);
                c_wa = AW'(r_ch);
                if (r_kind == swrr_pkg::KIND_SET) begin
                    t_we = 1'b1;
                    t_wd.spec = r_spec; t_wd.act = r_act; t_wd.avl = r_avl;
                end else begin
                    c_we = 1'b1;
                    c_wd = c_rd + swrr_pkg::FULL_SHARE;
                end
                n_state = S_FIN;
            end
            S_CLRC: begin
                c_we = 1'b1; c_wa = AW'(r_idx); c_wd = '0;
                if (r_idx + CW'(1) >= r_used) begin
                    n_state = S_FIN;
                end
            end
            S_SUM: begin
                if (walk_end) begin
                    n_state = (r_elig == '0) ? S_FIN : S_NRD;
                end
            end
            S_NRD: begin
                n_state = (r_idx >= r_used) ? S_FIN : S_NLD;
            end
            S_NLD: begin
                if (elig_ok) begin
                    n_state = S_DIV;
                end else begin
                    t_we = 1'b1; t_wd.norm = '0;
                    n_state = S_NRD;
                end
            end
            S_DIV: begin
                if (r_step == 5'd31) begin
                    n_state = (r_kind == swrr_pkg::KIND_SELECT) ? S_SCAN : S_NWB;
                end
            end
            S_NWB: begin
                t_we = 1'b1; t_wd = r_ent;
                t_wd.norm = r_quo;
                n_state = S_NRD;
            end
            S_UPD: begin
                if (r_rv && sel_ok) begin
                    c_we = 1'b1;
                end
                if (walk_end) begin
                    n_state = r_any ? S_DIV : S_FIN;
                end
            end
            S_SCAN: begin
                if (r_tie[AW'(r_idx)] && r_seen == r_rem[CW-1:0]) begin
                    c_we = 1'b1; c_wa = AW'(r_idx);
                    c_wd = r_best - swrr_pkg::FULL_SHARE;
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cfg   <= 4'd8;
            r_idx   <= '0;
            r_done  <= 1'b0;
            r_val   <= 1'b0;
            r_och   <= '0;
            r_ocr   <= '0;
            r_any   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            unique case (r_state)
                S_CLR: r_idx <= r_idx + CW'(1);
                S_IDLE: begin
                    r_idx   <= '0;
                    r_rv    <= 1'b0;
                    r_any   <= 1'b0;
                    r_total <= '0;
                    r_elig  <= '0;
                    r_cnt   <= '0;
                    r_step  <= '0;
                    r_rem   <= '0;
                    r_tie   <= '0;
                    r_seen  <= '0;
                    if (i_start) begin
                        r_kind <= i_kind; r_ch <= i_channel; r_spec <= i_spec_weight;
                        r_act <= i_active; r_avl <= i_available; r_dvd <= i_tie_random;
                        r_used <= used_c;
                    end
                end
                S_WB: ;
                S_CLRC: r_idx <= r_idx + CW'(1);
                S_SUM: begin
                    r_rv <= (r_idx < r_used);
                    r_pa <= AW'(r_idx);
                    if (r_idx < r_used) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_rv && elig_ok) begin
                        r_total <= r_total + 32'(t_rd.spec);
                        r_elig  <= r_elig + CW'(1);
                    end
                    if (walk_end) begin
                        r_idx <= '0;
                        r_div <= (r_total == '0) ? 32'(r_elig) : r_total;
                        r_eq  <= (r_total == '0);
                    end
                end
                S_NRD: ;
                S_NLD: begin
                    if (elig_ok) begin
                        r_ent  <= t_rd;
                        r_dvd  <= r_eq ? swrr_pkg::FULL_SHARE : {t_rd.spec, 16'h0000};
                        r_rem  <= '0;
                        r_step <= '0;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_DIV: begin
                    // restoring divider, one quotient bit per cycle
                    r_dvd  <= {r_dvd[30:0], 1'b0};
                    r_rem  <= take ? rem_sub[31:0] : rem_sh[31:0];
                    r_quo  <= {r_quo[swrr_pkg::NORM_W-2:0], take};
                    r_step <= r_step + 5'd1;
                end
                S_NWB: r_idx <= r_idx + CW'(1);
                S_UPD: begin
                    r_rv <= (r_idx < r_used);
                    r_pa <= AW'(r_idx);
                    if (r_idx < r_used) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_rv && sel_ok) begin
                        if (!r_any || key_add > key_best) begin
                            r_best <= cred_add;
                            r_cnt  <= CW'(1);
                            r_any  <= 1'b1;
                            r_tie  <= MAX_CHANNELS'(1) << r_pa;
                        end else if (cred_add == r_best) begin
                            r_cnt  <= r_cnt + CW'(1);
                            r_tie  <= r_tie | (MAX_CHANNELS'(1) << r_pa);
                        end
                    end
                    if (walk_end) begin
                        r_idx <= '0;
                    end
                end
                S_SCAN: begin
                    // remainder picks the tied channel in index order
                    r_idx <= r_idx + CW'(1);
                    if (r_tie[AW'(r_idx)]) begin
                        if (r_seen == r_rem[CW-1:0]) begin
                            r_win <= AW'(r_idx);
                        end else begin
                            r_seen <= r_seen + CW'(1);
                        end
                    end
                end
                S_FIN: begin
                    r_done <= 1'b1;
                    r_val  <= (r_kind == swrr_pkg::KIND_SELECT) && r_any;
                    r_och  <= (r_kind == swrr_pkg::KIND_SELECT && r_any) ? 3'(r_win) : '0;
                    r_ocr  <= (r_kind == swrr_pkg::KIND_SELECT && r_any) ? r_best : '0;
                end
                default: ;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_chosen_valid = r_val;
    assign o_chosen_channel = r_och;
    assign o_chosen_credit = r_ocr;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> r_done) else $error("result missing");
    a_valid_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_val) |-> r_kind == swrr_pkg::KIND_SELECT) else $error("bad valid");

endmodule
